@@ hw/rtl/rmsp_pkg.sv @@
// Types, constants and datapath step functions for the RMSprop update block.
package rmsp_pkg;

  localparam int ELEMENTS   = 4096;
  localparam int IDX_W      = $clog2(ELEMENTS);
  localparam int CLR_W      = IDX_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_LR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 2'd2;

  localparam logic [15:0] LR_RST    = 16'd655;
  localparam logic [16:0] DECAY_RST = 17'd58982;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [15:0] EPS_RST   = 16'd1;
  localparam logic [31:0] MS_RST    = 32'd65536;

  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;
  localparam int REM_W      = 28;
  localparam int SQ_STAGES  = 12;

  localparam int NUM_W      = 48;
  localparam int DEN_W      = 25;
  localparam int DIV_STAGES = 24;

  typedef struct packed {
    logic [IDX_W-1:0]  element_index;
    logic signed [31:0] weight;
    logic signed [31:0] gradient;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  result_index;
    logic signed [31:0] new_weight;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      w;
    logic             neg;
    logic [NUM_W-1:0] num;
  } sq_side_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      w;
    logic             neg;
  } dv_side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] n;
  } dv_step_t;

  function automatic sq_step_t sqrt_step(input logic [REM_W-1:0] rem,
                                         input logic [ROOT_W-1:0] root,
                                         input logic [1:0] pair);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] trial;
    sq_step_t o;
    r2    = {rem[REM_W-3:0], pair};
    trial = {2'b00, root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_step_t div_step(input logic [DEN_W-1:0] rem,
                                        input logic [NUM_W-1:0] n,
                                        input logic [DEN_W-1:0] den);
    logic [DEN_W:0] r;
    logic [DEN_W:0] diff;
    logic           ge;
    dv_step_t o;
    r    = {rem, n[NUM_W-1]};
    diff = r - {1'b0, den};
    ge   = (r >= {1'b0, den});
    o.rem = ge ? diff[DEN_W-1:0] : r[DEN_W-1:0];
    o.n   = {n[NUM_W-2:0], ge};
    return o;
  endfunction

endpackage

@@ hw/rtl/rmsp_sqrt.sv @@
// Pipelined integer square root, two root bits per stage.
module rmsp_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  rmsp_pkg::sq_side_t      in_side,
  input  logic [rmsp_pkg::RAD_W-1:0] in_rad,
  output logic                    out_v,
  output rmsp_pkg::sq_side_t      out_side,
  output logic [rmsp_pkg::ROOT_W-1:0] out_root
);
  import rmsp_pkg::*;

  logic              v_r    [SQ_STAGES];
  sq_side_t          side_r [SQ_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQ_STAGES];
  logic [REM_W-1:0]  rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0] root_r [SQ_STAGES];

  logic              v_c    [SQ_STAGES+1];
  sq_side_t          side_c [SQ_STAGES+1];
  logic [RAD_W-1:0]  rad_c  [SQ_STAGES+1];
  logic [REM_W-1:0]  rem_c  [SQ_STAGES+1];
  logic [ROOT_W-1:0] root_c [SQ_STAGES+1];

  assign v_c[0]    = in_v;
  assign side_c[0] = in_side;
  assign rad_c[0]  = in_rad;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    sq_step_t st_a;
    sq_step_t st_b;

    assign st_a = sqrt_step(rem_c[s], root_c[s], rad_c[s][RAD_W-1-4*s -: 2]);
    assign st_b = sqrt_step(st_a.rem, st_a.root, rad_c[s][RAD_W-3-4*s -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_c[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_c[s];
        rad_r[s]  <= rad_c[s];
        rem_r[s]  <= st_b.rem;
        root_r[s] <= st_b.root;
      end
    end

    assign v_c[s+1]    = v_r[s];
    assign side_c[s+1] = side_r[s];
    assign rad_c[s+1]  = rad_r[s];
    assign rem_c[s+1]  = rem_r[s];
    assign root_c[s+1] = root_r[s];
  end

  assign out_v    = v_c[SQ_STAGES];
  assign out_side = side_c[SQ_STAGES];
  assign out_root = root_c[SQ_STAGES];

endmodule

@@ hw/rtl/rmsp_div.sv @@
// Pipelined restoring divider, two quotient bits per stage.
module rmsp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  rmsp_pkg::dv_side_t         in_side,
  input  logic [rmsp_pkg::NUM_W-1:0] in_num,
  input  logic [rmsp_pkg::DEN_W-1:0] in_den,
  output logic                       out_v,
  output rmsp_pkg::dv_side_t         out_side,
  output logic [rmsp_pkg::NUM_W-1:0] out_quo
);
  import rmsp_pkg::*;

  logic             v_r    [DIV_STAGES];
  dv_side_t         side_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r  [DIV_STAGES];
  logic [DEN_W-1:0] rem_r  [DIV_STAGES];
  logic [NUM_W-1:0] n_r    [DIV_STAGES];

  logic             v_c    [DIV_STAGES+1];
  dv_side_t         side_c [DIV_STAGES+1];
  logic [DEN_W-1:0] den_c  [DIV_STAGES+1];
  logic [DEN_W-1:0] rem_c  [DIV_STAGES+1];
  logic [NUM_W-1:0] n_c    [DIV_STAGES+1];

  assign v_c[0]    = in_v;
  assign side_c[0] = in_side;
  assign den_c[0]  = in_den;
  assign rem_c[0]  = '0;
  assign n_c[0]    = in_num;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    dv_step_t st_a;
    dv_step_t st_b;

    assign st_a = div_step(rem_c[s], n_c[s], den_c[s]);
    assign st_b = div_step(st_a.rem, st_a.n, den_c[s]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_c[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_c[s];
        den_r[s]  <= den_c[s];
        rem_r[s]  <= st_b.rem;
        n_r[s]    <= st_b.n;
      end
    end

    assign v_c[s+1]    = v_r[s];
    assign side_c[s+1] = side_r[s];
    assign den_c[s+1]  = den_r[s];
    assign rem_c[s+1]  = rem_r[s];
    assign n_c[s+1]    = n_r[s];
  end

  assign out_v    = v_c[DIV_STAGES];
  assign out_side = side_c[DIV_STAGES];
  assign out_quo  = n_c[DIV_STAGES];

endmodule

@@ hw/rtl/rmsprop_weight_update.sv @@
// Top level: RMSprop weight update pipeline with per-element mean-square store.
//
//  channel | ports                          | transfer when
//  --------+--------------------------------+-----------------------
//  input   | in_valid, in_ready, in_data    | in_valid & in_ready
//  result  | out_valid, out_ready, out_data | out_valid & out_ready
//  config  | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// One item per cycle when the output does not stall; 5 front stages, 12 root
// stages, 1 denominator stage, 24 divider stages, 1 output stage.
// The mean-square read-modify-write closes in one stage with forwarding.
// After reset a clearing pass writes 1.0 to all 4096 entries, with in_ready
// low throughout. A stall at the output holds every stage.
module rmsprop_weight_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rmsp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rmsp_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rmsp_pkg::*;

  logic [15:0] lr_r;
  logic [16:0] decay_r;
  logic [15:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= LR_RST;
      decay_r <= DECAY_RST;
      eps_r   <= EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LR:    lr_r    <= cfg_wdata[15:0];
        REG_DECAY: decay_r <= cfg_wdata;
        REG_EPS:   eps_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [16:0] dc;
  logic [16:0] one_minus_d;
  assign dc          = (decay_r > ONE_Q16) ? ONE_Q16 : decay_r;
  assign one_minus_d = ONE_Q16 - dc;

  // clearing pass
  logic [CLR_W-1:0] clr_cnt_r;
  logic             clr_done;
  assign clr_done = clr_cnt_r[CLR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  logic out_valid_r;
  out_t out_data_r;
  logic adv;
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv && clr_done;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stage 1: input register
  logic s1_v_r;
  in_t  s1_r;
  // stage 2: magnitude
  logic             s2_v_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [31:0]      s2_w_r;
  logic             s2_neg_r;
  logic [31:0]      s2_gmag_r;
  // stage 3: products
  logic             s3_v_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [31:0]      s3_w_r;
  logic             s3_neg_r;
  logic [47:0]      s3_sq_r;
  logic [NUM_W-1:0] s3_num_r;
  // stage 4: blend
  logic             s4_v_r;
  sq_side_t         s4_side_r;
  logic [48:0]      s4_p_r;
  logic [31:0]      rd_r;
  // stage 5: new mean square
  logic             s5_v_r;
  sq_side_t         s5_side_r;
  logic [31:0]      s5_nm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid && clr_done;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  logic        s1_neg;
  logic [31:0] s1_gmag;
  assign s1_neg  = s1_r.gradient[31];
  assign s1_gmag = s1_neg ? (~s1_r.gradient + 32'd1) : s1_r.gradient;

  logic [63:0] s2_sq64;
  logic [NUM_W-1:0] s2_num;
  assign s2_sq64 = s2_gmag_r * s2_gmag_r;
  assign s2_num  = lr_r * s2_gmag_r;

  logic [31:0] s3_sq;
  logic [48:0] s3_p;
  assign s3_sq = (|s3_sq_r[47:32]) ? 32'hFFFF_FFFF : s3_sq_r[31:0];
  assign s3_p  = one_minus_d * s3_sq;

  logic        fwd;
  logic [31:0] m_sel;
  logic [49:0] blend;
  logic [31:0] nm;
  assign fwd   = s5_v_r && (s5_side_r.idx == s4_side_r.idx);
  assign m_sel = fwd ? s5_nm_r : rd_r;
  assign blend = 50'(dc * m_sel) + 50'(s4_p_r);
  assign nm    = (|blend[49:48]) ? 32'hFFFF_FFFF : blend[47:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r           <= in_data;
      s2_idx_r       <= s1_r.element_index;
      s2_w_r         <= s1_r.weight;
      s2_neg_r       <= s1_neg;
      s2_gmag_r      <= s1_gmag;
      s3_idx_r       <= s2_idx_r;
      s3_w_r         <= s2_w_r;
      s3_neg_r       <= s2_neg_r;
      s3_sq_r        <= s2_sq64[63:16];
      s3_num_r       <= s2_num;
      s4_side_r.idx  <= s3_idx_r;
      s4_side_r.w    <= s3_w_r;
      s4_side_r.neg  <= s3_neg_r;
      s4_side_r.num  <= s3_num_r;
      s4_p_r         <= s3_p;
      s5_side_r      <= s4_side_r;
      s5_nm_r        <= nm;
    end
  end

  logic [31:0] ms_mem [ELEMENTS];

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      ms_mem[clr_cnt_r[IDX_W-1:0]] <= MS_RST;
    end else if (adv && s4_v_r) begin
      ms_mem[s4_side_r.idx] <= nm;
    end
    if (adv) begin
      rd_r <= ms_mem[s3_idx_r];
    end
  end

  logic              sq_v;
  sq_side_t          sq_side;
  logic [ROOT_W-1:0] sq_root;

  rmsp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s5_v_r),
    .in_side  (s5_side_r),
    .in_rad   ({s5_nm_r, 16'h0000}),
    .out_v    (sq_v),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // denominator stage
  logic [DEN_W-1:0] den_sum;
  logic [DEN_W-1:0] den;
  assign den_sum = {1'b0, sq_root} + {{(DEN_W-16){1'b0}}, eps_r};
  assign den     = (den_sum == '0) ? {{(DEN_W-1){1'b0}}, 1'b1} : den_sum;

  logic             s6_v_r;
  dv_side_t         s6_side_r;
  logic [NUM_W-1:0] s6_num_r;
  logic [DEN_W-1:0] s6_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r.idx <= sq_side.idx;
      s6_side_r.w   <= sq_side.w;
      s6_side_r.neg <= sq_side.neg;
      s6_num_r      <= sq_side.num;
      s6_den_r      <= den;
    end
  end

  logic             dv_v;
  dv_side_t         dv_side;
  logic [NUM_W-1:0] dv_quo;

  rmsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_v     (s6_v_r),
    .in_side  (s6_side_r),
    .in_num   (s6_num_r),
    .in_den   (s6_den_r),
    .out_v    (dv_v),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  // weight update with saturation
  logic signed [49:0] w_ext;
  logic signed [49:0] q_ext;
  logic signed [49:0] nw_full;
  logic        [31:0] nw;
  assign w_ext   = {{18{dv_side.w[31]}}, dv_side.w};
  assign q_ext   = {2'b00, dv_quo};
  assign nw_full = dv_side.neg ? (w_ext + q_ext) : (w_ext - q_ext);
  assign nw = (nw_full > 50'sh0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF :
              (nw_full < -50'sh0_0000_8000_0000) ? 32'h8000_0000 : nw_full[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.result_index <= dv_side.idx;
      out_data_r.new_weight   <= nw;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> clr_done)
    else $error("transfer accepted during clearing pass");

  a_empty_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(clr_done) |-> !s1_v_r && !s5_v_r && !out_valid_r)
    else $error("pipeline not empty when clearing pass ends");

  a_write_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r || s6_v_r || dv_v |-> clr_done)
    else $error("store update before clearing pass finished");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the RMSprop weight update block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit failed;
  bit rx_stall_on;

  class rmsprop_scoreboard;
    logic [31:0] msq [ELEMENTS];
    logic [15:0] lr;
    logic [16:0] decay;
    logic [15:0] eps;
    out_t pending_q [$];

    function void clear();
      foreach (msq[i]) msq[i] = MS_RST;
      lr = LR_RST;
      decay = DECAY_RST;
      eps = EPS_RST;
      pending_q.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_LR: lr = v[15:0];
        REG_DECAY: decay = v;
        REG_EPS: eps = v[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_input(in_t it);
      longint signed w, g, stp, nw;
      longint unsigned mag, sq, d, nm, den, q;
      out_t o;
      w = longint'(it.weight);
      g = longint'(it.gradient);
      mag = (g < 0) ? -g : g;
      sq = (mag * mag) >> 16;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      d = (decay > ONE_Q16) ? 65536 : decay;
      nm = (d * msq[it.element_index] + (65536 - d) * sq) >> 16;
      if (nm > 64'hFFFF_FFFF) nm = 64'hFFFF_FFFF;
      msq[it.element_index] = nm[31:0];
      den = root64(nm << 16) + eps;
      if (den == 0) den = 1;
      q = (64'(lr) * mag) / den;
      stp = (g < 0) ? -longint'(q) : longint'(q);
      nw = w - stp;
      if (nw > 64'sd2147483647) nw = 64'sd2147483647;
      if (nw < -64'sd2147483648) nw = -64'sd2147483648;
      o.result_index = it.element_index;
      o.new_weight = nw[31:0];
      pending_q = {pending_q, o};
    endfunction

    function void check_result(out_t got);
      out_t exp_o;
      if (pending_q.size() == 0) begin
        $error("unexpected transfer: result_index %0d", got.result_index);
        failed = 1;
        return;
      end
      exp_o = pending_q.pop_front();
      if (got.result_index !== exp_o.result_index) begin
        $error("result_index exp %0d got %0d", exp_o.result_index, got.result_index);
        failed = 1;
      end
      if (got.new_weight !== exp_o.new_weight) begin
        $error("new_weight exp %0d got %0d", exp_o.new_weight, got.new_weight);
        failed = 1;
      end
    endfunction
  endclass

  rmsprop_scoreboard sb;

  rmsprop_weight_update DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rx_stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic send(in_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  function automatic in_t rand_item(bit hot);
    in_t it;
    it.element_index = hot ? 12'($urandom_range(0, 15)) : 12'($urandom);
    it.weight = $urandom;
    case ($urandom_range(0, 3))
      0: it.gradient = $urandom;
      1: it.gradient = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      2: it.gradient = $signed($urandom_range(0, 32'hFFF)) - 32'sh800;
      default: it.gradient = $signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000;
    endcase
    return it;
  endfunction

  task automatic random_phase(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && left > 0) begin
        send(rand_item(1'($urandom_range(0, 1))));
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
    end
    drain();
  endtask

  initial begin
    in_t it;
    logic signed [31:0] dw [6];
    logic signed [31:0] dg [7];
    sb = new();
    sb.clear();
    failed = 0;
    rx_stall_on = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 1;
    cfg_we = 0;
    cfg_index = REG_LR;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    dw = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh0001_0000, -32'sh1, 32'sh7FFF_0000};
    dg = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh1, -32'sh1, 32'sh0001_0000,
           -32'sh7FFF_0000};
    for (int i = 0; i < 7; i++) begin
      it.element_index = (i < 2) ? 12'hFFF : 12'(i);
      it.weight = dw[i % 6];
      it.gradient = dg[i];
      send(it);
    end
    drain();
    cfg_write(REG_LR, 17'd65535);
    drain();
    // max rate, full-scale gradient pulls weight past the rails
    it = '{12'd100, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF};
    send(it);
    it = '{12'd101, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send(it);
    drain();
    // zero denominator: decay zero clears the entry, eps zero
    cfg_write(REG_EPS, 17'd0);
    cfg_write(REG_DECAY, 17'd0);
    it = '{12'd200, 32'sh100, 0};
    send(it);
    drain();
    cfg_write(REG_DECAY, 17'h1FFFF);
    it = '{12'd200, 32'sh100, 32'sh50};
    send(it);
    send(it);
    drain();
    cfg_write(REG_UNUSED, 17'h1ABCD);

    rx_stall_on = 1;
    cfg_write(REG_DECAY, 17'd58982);
    cfg_write(REG_EPS, 17'd65535);
    cfg_write(REG_LR, 17'd655);
    random_phase(100);
    cfg_write(REG_DECAY, 17'd65536);
    cfg_write(REG_EPS, 17'd0);
    cfg_write(REG_LR, 17'd0);
    random_phase(60);
    cfg_write(REG_DECAY, 17'd0);
    cfg_write(REG_EPS, 17'd1);
    cfg_write(REG_LR, 17'd65535);
    random_phase(80);
    rx_stall_on = 0;
    random_phase(40);
    rx_stall_on = 1;
    cfg_write(REG_DECAY, 17'($urandom_range(0, 131071)));
    cfg_write(REG_EPS, 17'($urandom_range(0, 65535)));
    cfg_write(REG_LR, 17'($urandom_range(0, 65535)));
    random_phase(120);

    if (!failed && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.pending_q.size() != 0) $error("%0d results missing", sb.pending_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/rmsp_pkg.sv
hw/rtl/rmsp_sqrt.sv
hw/rtl/rmsp_div.sv
hw/rtl/rmsprop_weight_update.sv
tb/sv/tb.sv
